/* design/wbps_pkg.sv */
// Shared constants, widths and codes of the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

    // Default sizes of the scanner.
    localparam int PATTERN_MAX_DEF  = 64;
    localparam int ADDRESS_BITS_DEF = 48;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int PIDX_W     = 6;
    localparam int LEN_CFG_W  = 7;
    localparam int BASE_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;

    // Input item kinds carried on s_tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ONLY     = 2'd2;

endpackage

`default_nettype wire

/* design/wbps_pattern.sv */
// Pattern store and the aligner that lines pattern bytes up with the window cells.
`default_nettype none

module wbps_pattern #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [wbps_pkg::PIDX_W-1:0]    wr_index,
    input  wire logic [wbps_pkg::BYTE_W-1:0]    wr_byte,
    input  wire logic [LEN_W-1:0]               len_i,
    output logic      [wbps_pkg::BYTE_W-1:0]    mapped_o [PATTERN_MAX]
);

    localparam int SH_W = $clog2(PATTERN_MAX);

    logic [wbps_pkg::BYTE_W-1:0] pat_reg [PATTERN_MAX];
    logic [wbps_pkg::BYTE_W-1:0] map_reg [PATTERN_MAX];
    logic [wbps_pkg::BYTE_W-1:0] stg [SH_W+1][PATTERN_MAX];
    logic [SH_W-1:0]             shift_amt;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (wr_en && (32'(wr_index) == k)) begin
                pat_reg[k] <= wr_byte;
            end
        end
    end

    // Cell j compares against pattern byte len-1-j: reverse the store, then
    // shift down by PATTERN_MAX-len in log2 steps.
    assign shift_amt = SH_W'(32'(PATTERN_MAX) - 32'(len_i));

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            stg[0][j] = pat_reg[PATTERN_MAX-1-j];
        end
        for (int l = 0; l < SH_W; l++) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (!shift_amt[l]) begin
                    stg[l+1][j] = stg[l][j];
                end else if (j + (1 << l) < PATTERN_MAX) begin
                    stg[l+1][j] = stg[l][j + (1 << l)];
                end else begin
                    stg[l+1][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        map_reg <= stg[SH_W];
    end

    assign mapped_o = map_reg;

endmodule

`default_nettype wire

/* design/wbps_cell.sv */
// One window cell: holds a window byte, passes it on, and checks it against its pattern byte.
`default_nettype none

module wbps_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
) (
    input  wire logic                        aclk,
    input  wire logic                        shift_en,
    input  wire logic                        hit_en,
    input  wire logic [wbps_pkg::BYTE_W-1:0] byte_i,
    input  wire logic [wbps_pkg::BYTE_W-1:0] pat_i,
    input  wire logic [LEN_W-1:0]            len_i,
    output logic      [wbps_pkg::BYTE_W-1:0] byte_o,
    output logic                             hit_o
);

    logic [wbps_pkg::BYTE_W-1:0] win_reg;
    logic                        hit_reg;
    logic                        hit_next;
    logic                        active;
    logic                        head;

    assign active = 32'(len_i) > IDX;
    assign head   = 32'(len_i) == IDX + 1;

    // The head cell holds the candidate's first byte, which never takes a wildcard.
    always_comb begin
        if (!active) begin
            hit_next = 1'b1;
        end else if (head) begin
            hit_next = (win_reg == pat_i);
        end else begin
            hit_next = (pat_i == '0) || (win_reg == pat_i);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg <= byte_i;
        end
        if (hit_en) begin
            hit_reg <= hit_next;
        end
    end

    assign byte_o = win_reg;
    assign hit_o  = hit_reg;

endmodule

`default_nettype wire

/* design/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: handshakes, counter, cell row and result stage.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tuser kind, s_tdata index+byte, s_tlast
//  m_       out        m_tvalid / m_tready  m_tuser match, m_tdata address, m_tlast
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. A data byte enters the window
// row at acceptance, its cell compares are registered into stage B, and a result for
// a match or a region end is registered into the output register that drives m_tvalid.
// Reset (aresetn low at a clock edge) empties all stages and restores the registers.
// A stalled output holds the stages behind it; each stage refills as soon as it empties.
`default_nettype none

module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX  = wbps_pkg::PATTERN_MAX_DEF,
    parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [5:0] pattern_index, [13:6] item_byte, [15:14] zero
    input  wire logic [wbps_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [47:0] match_address
    output logic      [wbps_pkg::M_TDATA_W-1:0]    m_tdata,
    // match_valid
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration.
    logic [wbps_pkg::LEN_CFG_W-1:0] len_cfg_reg;
    logic [wbps_pkg::BASE_W-1:0]    region_base_reg;
    logic                           first_only_reg;
    logic [LEN_W-1:0]               len_eff;

    // Handshake and stage control.
    logic s_acc;
    logic data_acc;
    logic load_acc;
    logic adv_b;
    logic adv_c;
    logic a_leave;
    logic b_take;

    // Stage A: byte in the window row.
    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic [ADDRESS_BITS-1:0] cnt_reg;
    logic [ADDRESS_BITS-1:0] cnt_base;
    logic [ADDRESS_BITS-1:0] cnt_next;

    // Stage B: registered cell compares.
    logic                    b_valid_reg;
    logic                    b_last_reg;
    logic                    b_enough_reg;
    logic [ADDRESS_BITS-1:0] b_off_reg;
    logic [PATTERN_MAX-1:0]  hit_vec;

    // Result stage.
    logic                           found_reg;
    logic                           m_valid_reg;
    logic [wbps_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                           m_match_reg;
    logic                           m_done_reg;
    logic                           hit;
    logic                           report;
    logic [ADDRESS_BITS-1:0]        addr_sum;

    logic [wbps_pkg::BYTE_W-1:0] mapped   [PATTERN_MAX];
    logic [wbps_pkg::BYTE_W-1:0] win_link [PATTERN_MAX+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg     <= wbps_pkg::LEN_CFG_W'(1);
            region_base_reg <= '0;
            first_only_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                wbps_pkg::REG_PATTERN_LENGTH: begin
                    len_cfg_reg <= cfg_data[wbps_pkg::LEN_CFG_W-1:0];
                end
                wbps_pkg::REG_REGION_BASE: begin
                    region_base_reg <= cfg_data[wbps_pkg::BASE_W-1:0];
                end
                wbps_pkg::REG_FIRST_ONLY: begin
                    first_only_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(len_cfg_reg) > PATTERN_MAX) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(len_cfg_reg);
        end
    end

    assign adv_c    = !m_valid_reg || m_tready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign s_tready = !a_valid_reg || adv_b;
    assign s_acc    = s_tvalid && s_tready;
    assign data_acc = s_acc && (s_tuser == wbps_pkg::REQ_DATA);
    assign load_acc = s_acc && (s_tuser == wbps_pkg::REQ_LOAD);
    assign a_leave  = a_valid_reg && adv_b;
    assign b_take   = b_valid_reg && adv_c;

    // The count restarts when the region's last byte leaves stage A.
    assign cnt_base = (a_leave && a_last_reg) ? '0 : cnt_reg;
    assign cnt_next = (&cnt_base) ? cnt_base : cnt_base + ADDRESS_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (data_acc) begin
                a_valid_reg <= 1'b1;
                cnt_reg     <= cnt_next;
            end else begin
                if (a_leave) begin
                    a_valid_reg <= 1'b0;
                end
                cnt_reg <= cnt_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (data_acc) begin
            a_last_reg <= s_tlast;
        end
    end

    wbps_pattern #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_pattern (
        .aclk     (aclk),
        .wr_en    (load_acc),
        .wr_index (s_tdata[wbps_pkg::PIDX_W-1:0]),
        .wr_byte  (s_tdata[wbps_pkg::PIDX_W +: wbps_pkg::BYTE_W]),
        .len_i    (len_eff),
        .mapped_o (mapped)
    );

    assign win_link[0] = s_tdata[wbps_pkg::PIDX_W +: wbps_pkg::BYTE_W];

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        wbps_cell #(
            .IDX   (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (data_acc),
            .hit_en   (adv_b),
            .byte_i   (win_link[j]),
            .pat_i    (mapped[j]),
            .len_i    (len_eff),
            .byte_o   (win_link[j+1]),
            .hit_o    (hit_vec[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_b) begin
            b_last_reg   <= a_last_reg;
            b_enough_reg <= cnt_reg >= ADDRESS_BITS'(len_eff);
            b_off_reg    <= cnt_reg - ADDRESS_BITS'(len_eff);
        end
    end

    assign hit      = b_enough_reg && (&hit_vec);
    assign report   = hit && !(first_only_reg && found_reg);
    assign addr_sum = ADDRESS_BITS'(region_base_reg) + b_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (b_take && (report || b_last_reg)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (b_take) begin
                found_reg <= b_last_reg ? 1'b0 : (found_reg || hit);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_take && (report || b_last_reg)) begin
            m_match_reg <= report;
            m_done_reg  <= b_last_reg;
            m_data_reg  <= report ? wbps_pkg::M_TDATA_W'(addr_sum) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_match_reg;
    assign m_tlast  = m_done_reg;

    // A result always reports a match, the end of a region, or both.
    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_match_reg || m_done_reg))
        else $error("result item without match or region end");

    // A result without a match carries a zero address.
    a_nomatch_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_match_reg) |-> (m_data_reg == '0))
        else $error("non-match result with nonzero address");

    // The end of a region clears the found flag.
    a_found_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_take && b_last_reg) |=> !found_reg)
        else $error("found flag survived region end");

    // A data byte taken in always occupies the window stage next cycle.
    a_data_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        data_acc |=> a_valid_reg)
        else $error("accepted data byte lost before compare");

endmodule

`default_nettype wire
